// ===== rtl/core/weighted_2d_histogram_binner_top_macros.svh =====
// ----------------------------------------------------------------------------
// Weighted 2D histogram binner: assertion macros
// Shared concurrent assertion forms for the binner's checks.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_2D_HISTOGRAM_BINNER_TOP_MACROS_SVH
`define WEIGHTED_2D_HISTOGRAM_BINNER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WHB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WHB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/whb_pkg.sv =====
// ----------------------------------------------------------------------------
// whb_pkg
// Types, sizes and codes shared by the weighted 2D histogram binner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package whb_pkg;

  // Histogram geometry.
  localparam int MAX_X_BINS = 32;
  localparam int MAX_Y_BINS = 32;
  localparam int BIN_DEPTH  = MAX_X_BINS * MAX_Y_BINS;
  localparam int BIN_AW     = $clog2(BIN_DEPTH);
  localparam int EDGE_DEPTH = (MAX_X_BINS > MAX_Y_BINS) ? MAX_X_BINS + 1 : MAX_Y_BINS + 1;
  localparam int EDGE_AW    = $clog2(EDGE_DEPTH);

  // Field widths.
  localparam int OP_W       = 3;
  localparam int SLOT_W     = 10;
  localparam int VAL_W      = 32;
  localparam int SUM_W      = 48;
  localparam int HITS_W     = 24;
  localparam int CNT_W      = 6;
  localparam int IDX_W      = 2 * CNT_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // Request queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Edge counts.
  localparam logic [CNT_W-1:0] X_EDGES   = CNT_W'(MAX_X_BINS + 1);
  localparam logic [CNT_W-1:0] Y_EDGES   = CNT_W'(MAX_Y_BINS + 1);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(33);

  // Saturation limits.
  localparam logic [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD_X = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_Y = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
  localparam logic [OP_W-1:0] OP_READ   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_X_EDGE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_EDGE_COUNT = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [SLOT_W-1:0]        slot;
    logic signed [VAL_W-1:0]  x_value;
    logic signed [VAL_W-1:0]  y_value;
    logic signed [VAL_W-1:0]  weight;
  } whb_in_t;

  typedef struct packed {
    logic                     in_range;
    logic [SLOT_W-1:0]        bin_number;
    logic signed [SUM_W-1:0]  bin_sum;
    logic [HITS_W-1:0]        bin_hits;
  } whb_out_t;

  typedef enum logic [2:0] {
    CMD_LOAD_X,
    CMD_LOAD_Y,
    CMD_ADD,
    CMD_READ,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  // Classified request as it sits in the queue.
  typedef struct packed {
    cmd_kind_t                kind;
    logic                     slot_ok;
    logic [SLOT_W-1:0]        slot;
    logic signed [VAL_W-1:0]  x_value;
    logic signed [VAL_W-1:0]  y_value;
    logic signed [VAL_W-1:0]  weight;
  } whb_cmd_t;

  typedef struct packed {
    logic     valid;
    whb_cmd_t cmd;
  } whb_qout_t;

  // Control into one axis search unit.
  typedef struct packed {
    logic                     start;
    logic signed [VAL_W-1:0]  key;
    logic [CNT_W-1:0]         n;
    logic                     ld_en;
    logic [EDGE_AW-1:0]       ld_addr;
    logic signed [VAL_W-1:0]  ld_data;
  } srch_req_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] pos;
  } srch_rsp_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [HITS_W-1:0]       hits;
  } bin_entry_t;

  typedef enum logic [1:0] {
    SR_IDLE,
    SR_READ,
    SR_CMP
  } srch_state_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_START,
    BK_SEARCH,
    BK_INDEX,
    BK_READ,
    BK_UPDATE,
    BK_OUT
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/whb_front.sv =====
// ----------------------------------------------------------------------------
// whb_front
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module whb_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire whb_pkg::whb_in_t   in_data,
  input  wire logic               init_busy,
  input  wire logic               q_pop,
  output whb_pkg::whb_qout_t      q_out
);

  whb_pkg::whb_cmd_t                q_mem_r [0:whb_pkg::Q_DEPTH-1];
  logic [whb_pkg::Q_AW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [whb_pkg::Q_AW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [whb_pkg::Q_CW-1:0]         cnt_r, cnt_nxt;
  logic                             push;
  whb_pkg::whb_cmd_t                cmd;

  // Decode the operation and check the slot for its use.
  always_comb begin
    cmd.slot    = in_data.slot;
    cmd.x_value = in_data.x_value;
    cmd.y_value = in_data.y_value;
    cmd.weight  = in_data.weight;
    unique case (in_data.operation)
      whb_pkg::OP_LOAD_X: begin
        cmd.kind    = whb_pkg::CMD_LOAD_X;
        cmd.slot_ok = (32'(in_data.slot) <= whb_pkg::MAX_X_BINS);
      end
      whb_pkg::OP_LOAD_Y: begin
        cmd.kind    = whb_pkg::CMD_LOAD_Y;
        cmd.slot_ok = (32'(in_data.slot) <= whb_pkg::MAX_Y_BINS);
      end
      whb_pkg::OP_ADD: begin
        cmd.kind    = whb_pkg::CMD_ADD;
        cmd.slot_ok = 1'b0;
      end
      whb_pkg::OP_READ: begin
        cmd.kind    = whb_pkg::CMD_READ;
        cmd.slot_ok = (32'(in_data.slot) < whb_pkg::BIN_DEPTH);
      end
      whb_pkg::OP_CLEAR: begin
        cmd.kind    = whb_pkg::CMD_CLEAR;
        cmd.slot_ok = 1'b0;
      end
      default: begin
        cmd.kind    = whb_pkg::CMD_NOP;
        cmd.slot_ok = 1'b0;
      end
    endcase
  end

  // Queue occupancy and pointers.
  assign in_stall = (cnt_r == whb_pkg::Q_CW'(whb_pkg::Q_DEPTH)) || init_busy;
  assign push     = in_valid && !in_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == whb_pkg::Q_AW'(whb_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == whb_pkg::Q_AW'(whb_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

  assign q_out.valid = (cnt_r != '0);
  assign q_out.cmd   = q_mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/core/whb_search.sv =====
// ----------------------------------------------------------------------------
// whb_search
// Edge table of one axis with an iterative lower-bound search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module whb_search (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire whb_pkg::srch_req_t  req,
  output whb_pkg::srch_rsp_t       rsp
);

  logic signed [whb_pkg::VAL_W-1:0] edge_mem_r [0:whb_pkg::EDGE_DEPTH-1];
  logic signed [whb_pkg::VAL_W-1:0] rd_data_r;
  whb_pkg::srch_state_t             state_r, state_nxt;
  logic [whb_pkg::CNT_W-1:0]        lo_r, lo_nxt;
  logic [whb_pkg::CNT_W-1:0]        hi_r, hi_nxt;
  logic [whb_pkg::EDGE_AW-1:0]      mid_r, mid_nxt;
  logic signed [whb_pkg::VAL_W-1:0] key_r, key_nxt;
  logic [whb_pkg::CNT_W:0]          mid_sum;
  logic [whb_pkg::EDGE_AW-1:0]      mid_w;

  // Midpoint of the half-open search interval.
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w   = whb_pkg::EDGE_AW'(mid_sum >> 1);

  // Search sequencer: one read and one compare per halving step.
  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    unique case (state_r)
      whb_pkg::SR_IDLE: begin
        if (req.start) begin
          key_nxt = req.key;
          lo_nxt  = '0;
          hi_nxt  = req.n;
          if (req.n != '0) begin
            state_nxt = whb_pkg::SR_READ;
          end
        end
      end
      whb_pkg::SR_READ: begin
        mid_nxt   = mid_w;
        state_nxt = whb_pkg::SR_CMP;
      end
      whb_pkg::SR_CMP: begin
        if (key_r <= rd_data_r) begin
          hi_nxt = whb_pkg::CNT_W'(mid_r);
        end else begin
          lo_nxt = whb_pkg::CNT_W'(mid_r) + 1'b1;
        end
        state_nxt = (lo_nxt < hi_nxt) ? whb_pkg::SR_READ : whb_pkg::SR_IDLE;
      end
      default: begin
        state_nxt = whb_pkg::SR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= whb_pkg::SR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
  end

  // Edge storage: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (req.ld_en) begin
      edge_mem_r[req.ld_addr] <= req.ld_data;
    end
    rd_data_r <= edge_mem_r[mid_w];
  end

  assign rsp.busy = (state_r != whb_pkg::SR_IDLE);
  assign rsp.pos  = lo_r;

endmodule

`default_nettype wire

// ===== rtl/core/whb_back.sv =====
// ----------------------------------------------------------------------------
// whb_back
// Executes queued requests: edge loads, bin updates, reads and clears.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module whb_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [whb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [whb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire whb_pkg::whb_qout_t                  q_in,
  output logic                                     q_pop,
  output logic                                     init_busy,
  output whb_pkg::srch_req_t                       x_req,
  output whb_pkg::srch_req_t                       y_req,
  input  wire whb_pkg::srch_rsp_t                  x_rsp,
  input  wire whb_pkg::srch_rsp_t                  y_rsp,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output whb_pkg::whb_out_t                        out_data
);

  whb_pkg::bin_entry_t           bin_mem_r [0:whb_pkg::BIN_DEPTH-1];
  whb_pkg::bin_entry_t           rd_data_r;
  whb_pkg::back_state_t          state_r, state_nxt;
  logic [whb_pkg::BIN_AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                          from_op_r, from_op_nxt;
  whb_pkg::whb_cmd_t             cmd_r, cmd_nxt;
  logic [whb_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  whb_pkg::whb_out_t             res_r, res_nxt;
  logic                          out_valid_r;
  whb_pkg::whb_out_t             out_data_r;
  logic [whb_pkg::CNT_W-1:0]     x_cnt_r, y_cnt_r;
  logic [whb_pkg::CNT_W-1:0]     nx, ny;
  logic                          out_load;
  logic                          mem_we;
  logic [whb_pkg::BIN_AW-1:0]    mem_waddr;
  logic [whb_pkg::BIN_AW-1:0]    mem_raddr;
  whb_pkg::bin_entry_t           mem_wdata;

  // Edge counts in use, limited to the table depth.
  assign nx = (x_cnt_r > whb_pkg::X_EDGES) ? whb_pkg::X_EDGES : x_cnt_r;
  assign ny = (y_cnt_r > whb_pkg::Y_EDGES) ? whb_pkg::Y_EDGES : y_cnt_r;

  // Sequencer: next state, memory controls and search requests.
  always_comb begin
    logic [whb_pkg::CNT_W-1:0] xm1;
    logic [whb_pkg::CNT_W-1:0] ym1;
    logic [whb_pkg::CNT_W-1:0] nxm1;
    logic [whb_pkg::SUM_W:0]   sum_ext;
    logic [whb_pkg::SUM_W-1:0] new_sum;
    logic [whb_pkg::HITS_W-1:0] new_hits;

    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    from_op_nxt = from_op_r;
    cmd_nxt     = cmd_r;
    idx_nxt     = idx_r;
    res_nxt     = res_r;
    q_pop       = 1'b0;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = whb_pkg::BIN_AW'(idx_r);
    mem_raddr   = whb_pkg::BIN_AW'(idx_r);
    mem_wdata   = '0;

    x_req       = '0;
    y_req       = '0;
    x_req.key   = cmd_r.x_value;
    y_req.key   = cmd_r.y_value;
    x_req.n     = nx;
    y_req.n     = ny;

    xm1  = x_rsp.pos - 1'b1;
    ym1  = y_rsp.pos - 1'b1;
    nxm1 = nx - 1'b1;

    // Saturating bin update from the entry read last cycle.
    sum_ext = {rd_data_r.sum[whb_pkg::SUM_W-1], rd_data_r.sum}
            + {{(whb_pkg::SUM_W + 1 - whb_pkg::VAL_W){cmd_r.weight[whb_pkg::VAL_W-1]}},
               cmd_r.weight};
    if (sum_ext[whb_pkg::SUM_W] != sum_ext[whb_pkg::SUM_W-1]) begin
      new_sum = sum_ext[whb_pkg::SUM_W] ? whb_pkg::SUM_MIN : whb_pkg::SUM_MAX;
    end else begin
      new_sum = sum_ext[whb_pkg::SUM_W-1:0];
    end
    new_hits = (rd_data_r.hits == whb_pkg::HITS_MAX) ? rd_data_r.hits
                                                      : rd_data_r.hits + 1'b1;

    unique case (state_r)
      // Zero one bin per cycle.
      whb_pkg::BK_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == whb_pkg::BIN_AW'(whb_pkg::BIN_DEPTH - 1)) begin
          from_op_nxt = 1'b0;
          state_nxt   = from_op_r ? whb_pkg::BK_OUT : whb_pkg::BK_IDLE;
        end
      end
      // Take the next request from the queue.
      whb_pkg::BK_IDLE: begin
        mem_raddr = whb_pkg::BIN_AW'(q_in.cmd.slot);
        if (q_in.valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_in.cmd;
          res_nxt = '0;
          unique case (q_in.cmd.kind)
            whb_pkg::CMD_LOAD_X: begin
              x_req.ld_en   = q_in.cmd.slot_ok;
              x_req.ld_addr = whb_pkg::EDGE_AW'(q_in.cmd.slot);
              x_req.ld_data = q_in.cmd.x_value;
              state_nxt     = whb_pkg::BK_OUT;
            end
            whb_pkg::CMD_LOAD_Y: begin
              y_req.ld_en   = q_in.cmd.slot_ok;
              y_req.ld_addr = whb_pkg::EDGE_AW'(q_in.cmd.slot);
              y_req.ld_data = q_in.cmd.x_value;
              state_nxt     = whb_pkg::BK_OUT;
            end
            whb_pkg::CMD_ADD: begin
              state_nxt = whb_pkg::BK_START;
            end
            whb_pkg::CMD_READ: begin
              res_nxt.bin_number = q_in.cmd.slot;
              state_nxt = q_in.cmd.slot_ok ? whb_pkg::BK_READ : whb_pkg::BK_OUT;
            end
            whb_pkg::CMD_CLEAR: begin
              clr_cnt_nxt = '0;
              from_op_nxt = 1'b1;
              state_nxt   = whb_pkg::BK_CLEAR;
            end
            default: begin
              state_nxt = whb_pkg::BK_OUT;
            end
          endcase
        end
      end
      // Launch both axis searches.
      whb_pkg::BK_START: begin
        x_req.start = 1'b1;
        y_req.start = 1'b1;
        state_nxt   = whb_pkg::BK_SEARCH;
      end
      // Range check and bin index once both searches end.
      whb_pkg::BK_SEARCH: begin
        if (!x_rsp.busy && !y_rsp.busy) begin
          idx_nxt = whb_pkg::IDX_W'(ym1) * whb_pkg::IDX_W'(nxm1) + whb_pkg::IDX_W'(xm1);
          if (x_rsp.pos != '0 && x_rsp.pos != nx && y_rsp.pos != '0 && y_rsp.pos != ny) begin
            state_nxt = whb_pkg::BK_INDEX;
          end else begin
            state_nxt = whb_pkg::BK_OUT;
          end
        end
      end
      // Bin read is issued here at the registered index.
      whb_pkg::BK_INDEX: begin
        state_nxt = (32'(idx_r) < whb_pkg::BIN_DEPTH) ? whb_pkg::BK_UPDATE : whb_pkg::BK_OUT;
      end
      whb_pkg::BK_READ: begin
        res_nxt.bin_sum  = rd_data_r.sum;
        res_nxt.bin_hits = rd_data_r.hits;
        state_nxt        = whb_pkg::BK_OUT;
      end
      // Write back the updated bin.
      whb_pkg::BK_UPDATE: begin
        mem_we             = 1'b1;
        mem_wdata.sum      = new_sum;
        mem_wdata.hits     = new_hits;
        res_nxt.in_range   = 1'b1;
        res_nxt.bin_number = whb_pkg::SLOT_W'(idx_r);
        res_nxt.bin_sum    = new_sum;
        res_nxt.bin_hits   = new_hits;
        state_nxt          = whb_pkg::BK_OUT;
      end
      // Hand the result to the output register once it is free.
      whb_pkg::BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = whb_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = whb_pkg::BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= whb_pkg::BK_CLEAR;
      clr_cnt_r   <= '0;
      from_op_r   <= 1'b0;
      out_valid_r <= 1'b0;
      x_cnt_r     <= whb_pkg::CNT_RESET;
      y_cnt_r     <= whb_pkg::CNT_RESET;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      from_op_r <= from_op_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          whb_pkg::CFG_X_EDGE_COUNT: x_cnt_r <= whb_pkg::CNT_W'(cfg_data);
          whb_pkg::CFG_Y_EDGE_COUNT: y_cnt_r <= whb_pkg::CNT_W'(cfg_data);
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // Bin store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= bin_mem_r[mem_raddr];
  end

  assign init_busy = (state_r == whb_pkg::BK_CLEAR) && !from_op_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/weighted_2d_histogram_binner_top.sv =====
// Flow: an add runs both axis lower-bound searches before its bin update; a clear zeroes
//   every bin before its result is handed out.
// Throughput: one request at a time in the back end; the edge search loop (read, compare)
//   and the bin store read and write set the add rate. A two-entry queue sits in front.
// Reset: synchronous, active low; afterwards the bin store is zeroed in a pass over every bin
//   during which in_stall is high. Edge counts reset to 33; edge tables stay unwritten.
// ----------------------------------------------------------------------------
// weighted_2d_histogram_binner_top
// Weighted 2D histogram binner: edge tables, bin search and saturating bins.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_2d_histogram_binner_top_macros.svh"

module weighted_2d_histogram_binner_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire whb_pkg::whb_in_t                in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output whb_pkg::whb_out_t                    out_data,
  input  wire logic                            cfg_we,
  input  wire logic [whb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [whb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  whb_pkg::whb_qout_t  q_out;
  logic                q_pop;
  logic                init_busy;
  whb_pkg::srch_req_t  x_req, y_req;
  whb_pkg::srch_rsp_t  x_rsp, y_rsp;

  // Request intake and queue.
  whb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .init_busy (init_busy),
    .q_pop     (q_pop),
    .q_out     (q_out)
  );

  // Per-axis edge tables and searches.
  whb_search u_x_search (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (x_req),
    .rsp   (x_rsp)
  );

  whb_search u_y_search (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (y_req),
    .rsp   (y_rsp)
  );

  // Execution, bin store and output register.
  whb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_in      (q_out),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .x_req     (x_req),
    .y_req     (y_req),
    .x_rsp     (x_rsp),
    .y_rsp     (y_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A bin hit always reports at least one sample.
  `WHB_ASSERT_SAME(a_hit_counts, clk, rst_n, out_valid && out_data.in_range, out_data.bin_hits != '0, "bin hit with zero count")

  // The back end only pops a request that is present.
  `WHB_ASSERT_SAME(a_pop_valid, clk, rst_n, q_pop, q_out.valid, "pop from empty queue")

  // A search is never started while one is still running.
  `WHB_ASSERT_SAME(a_start_idle, clk, rst_n, x_req.start || y_req.start, !x_rsp.busy && !y_rsp.busy, "search started while busy")

  // After a start the search runs, or ends at once at position zero.
  `WHB_ASSERT_NEXT(a_start_runs, clk, rst_n, x_req.start, x_rsp.busy || x_rsp.pos == '0, "search start lost")

endmodule

`default_nettype wire
